// File: rtl/fasc_pkg.sv
// fasc_pkg: shared constants, types and decode functions for the framed
// attenuator and switch control block. no dependencies.

package fasc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AttW   = 5;
  localparam int unsigned SwW    = 4;
  localparam int unsigned HistN  = 4;
  localparam int unsigned ResW   = 1 + 4 * AttW + SwW;
  localparam int unsigned ResPadW = ((ResW + 7) / 8) * 8;

  // frame bytes
  localparam logic [ByteW-1:0] HdrByte = 8'hAA;
  localparam logic [ByteW-1:0] TrlByte = 8'h55;
  localparam logic [ByteW-1:0] SumMask = 8'h0F;

  // switch commands, compared on the whole byte
  localparam logic [ByteW-1:0] CmdOfdm  = 8'h01;
  localparam logic [ByteW-1:0] CmdEcho  = 8'h02;
  localparam logic [ByteW-1:0] CmdUphop = 8'h04;

  localparam logic [AttW-1:0] AttAllOnes = 5'h1F;
  localparam logic [AttW-1:0] AttZero    = 5'h00;

  // switch bit positions: S12, S3, S4, S5 from bit 0 up
  localparam int unsigned SwS12 = 0;
  localparam int unsigned SwS3  = 1;
  localparam int unsigned SwS4  = 2;
  localparam int unsigned SwS5  = 3;

  localparam logic [SwW-1:0] SwEcho  = 4'b1010;  // S3 and S5
  localparam logic [SwW-1:0] SwUphop = 4'b1101;  // S12, S4 and S5
  localparam logic [SwW-1:0] SwReset = SwEcho;

  // attenuator mode from data bits 6:5
  typedef enum logic [1:0] {
    MODE_ST4 = 2'd0,
    MODE_ST3 = 2'd1,
    MODE_ST2 = 2'd2,
    MODE_ST1 = 2'd3
  } att_mode_e;

  // checked frame as seen on the byte that completes it
  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] cmd;
  } frame_t;

  // control words of the four stages, stage 4 first
  typedef struct packed {
    logic [AttW-1:0] st4;
    logic [AttW-1:0] st3;
    logic [AttW-1:0] st2;
    logic [AttW-1:0] st1;
  } att_t;

  // low five bits plus one, wrapping; zero turns into all ones
  function automatic logic [AttW-1:0] bumped(input logic [AttW-1:0] low5);
    logic [AttW-1:0] v;
    v = low5 + AttW'(1);
    return (v == AttZero) ? AttAllOnes : v;
  endfunction

endpackage

// File: rtl/fasc_frame_check.sv
// fasc_frame_check: four-byte history and the frame check on each new byte.
// depends on fasc_pkg.

module fasc_frame_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [fasc_pkg::ByteW-1:0]   byte_i,
  output fasc_pkg::frame_t             frame_o
);

  // entry 0 is the oldest byte
  logic [fasc_pkg::HistN-1:0][fasc_pkg::ByteW-1:0] hist_q, hist_d;
  logic [fasc_pkg::ByteW-1:0] sum;

  assign sum = (hist_q[1] + hist_q[2]) & fasc_pkg::SumMask;

  always_comb begin
    frame_o.ok   = (hist_q[0] == fasc_pkg::HdrByte) && (byte_i == fasc_pkg::TrlByte) &&
                   (hist_q[3] == sum);
    frame_o.data = hist_q[1];
    frame_o.cmd  = hist_q[2];
  end

  always_comb begin
    hist_d = hist_q;
    if (accept_i) begin
      hist_d = {byte_i, hist_q[3], hist_q[2], hist_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

endmodule

// File: rtl/fasc_ctrl_state.sv
// fasc_ctrl_state: attenuator words and switch bits, updated by checked frames.
// depends on fasc_pkg.

module fasc_ctrl_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  fasc_pkg::frame_t           frame_i,
  output fasc_pkg::att_t             att_d_o,
  output logic [fasc_pkg::SwW-1:0]   sw_d_o
);

  fasc_pkg::att_t             att_q, att_d, att_dec;
  logic [fasc_pkg::SwW-1:0]   sw_q, sw_d, sw_dec;
  fasc_pkg::att_mode_e        mode;
  logic [fasc_pkg::AttW-1:0]  low5, bump;

  assign mode = fasc_pkg::att_mode_e'(frame_i.data[6:5]);
  assign low5 = frame_i.data[fasc_pkg::AttW-1:0];
  assign bump = fasc_pkg::bumped(low5);

  always_comb begin
    att_dec = att_q;
    // data of 128 or more keeps the attenuators
    if (!frame_i.data[fasc_pkg::ByteW-1]) begin
      case (mode)
        fasc_pkg::MODE_ST4: att_dec = '{low5, fasc_pkg::AttZero, fasc_pkg::AttZero,
                                         fasc_pkg::AttZero};
        fasc_pkg::MODE_ST3: att_dec = '{fasc_pkg::AttAllOnes, bump, fasc_pkg::AttZero,
                                         fasc_pkg::AttZero};
        fasc_pkg::MODE_ST2: att_dec = '{fasc_pkg::AttAllOnes, fasc_pkg::AttAllOnes, bump,
                                         fasc_pkg::AttZero};
        fasc_pkg::MODE_ST1: att_dec = '{fasc_pkg::AttAllOnes, fasc_pkg::AttAllOnes,
                                         fasc_pkg::AttAllOnes, bump};
        default:            att_dec = att_q;
      endcase
    end
  end

  always_comb begin
    sw_dec = sw_q;
    case (frame_i.cmd)
      fasc_pkg::CmdOfdm: begin
        sw_dec = sw_q;
        sw_dec[fasc_pkg::SwS5] = 1'b0;
      end
      fasc_pkg::CmdEcho:  sw_dec = fasc_pkg::SwEcho;
      fasc_pkg::CmdUphop: sw_dec = fasc_pkg::SwUphop;
      default:            sw_dec = sw_q;
    endcase
  end

  always_comb begin
    att_d = att_q;
    sw_d  = sw_q;
    if (accept_i && frame_i.ok) begin
      att_d = att_dec;
      sw_d  = sw_dec;
    end
  end

  assign att_d_o = att_d;
  assign sw_d_o  = sw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q <= '0;
      sw_q  <= fasc_pkg::SwReset;
    end else begin
      att_q <= att_d;
      sw_q  <= sw_d;
    end
  end

endmodule

// File: rtl/framed_attenuator_and_switch_control_top.sv
// framed_attenuator_and_switch_control_top: stream wrapper with the result register.
// depends on fasc_pkg, fasc_frame_check and fasc_ctrl_state.

// Takes one received byte per slave transfer and returns one result per byte.
// Each byte is checked with the four before it as a frame: header 0xAA, data,
// command, checksum ((data + command) and 0x0F), trailer 0x55. Frames may
// overlap; there is no resync. A valid frame loads the four 5-bit attenuator
// words from the data byte (bits 6:5 select how many upper stages go to all
// ones; data of 128 or more leaves them alone) and the switch bits from the
// command byte (0x01 clears S5, 0x02 and 0x04 load fixed patterns). The result
// shows frame_ok and the state after the byte. The result of a slave transfer
// is registered into the output register; a byte can be taken
// every cycle, and the slave side stalls only while a result waits in the
// output register and the master side holds tready low.

module framed_attenuator_and_switch_control_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave side
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [fasc_pkg::ByteW-1:0]       s_axis_tdata_i,   // rx_byte
  // master side
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // frame_ok, att_stage4, att_stage3, att_stage2, att_stage1,
  // sw_a, sw_b, sw_c, sw_d, zero fill
  output logic [fasc_pkg::ResPadW-1:0]     m_axis_tdata_o
);

  logic                             accept;
  fasc_pkg::frame_t                 frame;
  fasc_pkg::att_t                   att_d;
  logic [fasc_pkg::SwW-1:0]         sw_d;
  logic                             out_valid_q, out_valid_d;
  logic [fasc_pkg::ResW-1:0]        res_q, res_d;

  // take a byte when the result register is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  fasc_frame_check u_frame_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .frame_o  (frame)
  );

  fasc_ctrl_state u_ctrl_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .frame_i  (frame),
    .att_d_o  (att_d),
    .sw_d_o   (sw_d)
  );

  // result word, frame_ok in bit 0
  assign res_d = {sw_d[fasc_pkg::SwS5], sw_d[fasc_pkg::SwS4], sw_d[fasc_pkg::SwS3],
                  sw_d[fasc_pkg::SwS12], att_d.st1, att_d.st2, att_d.st3, att_d.st4,
                  frame.ok};

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(fasc_pkg::ResPadW - fasc_pkg::ResW){1'b0}}, res_q};

endmodule
